FILE: hw/rtl/ort_pkg.sv
// package for the outstanding request tracker: sizes, codes and transaction types
package ort_pkg;

  localparam int SLOTS       = 8;
  localparam int MAX_RESULTS = 8;
  localparam int SLOT_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int POS_W       = $clog2(SLOTS + 1);
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

  localparam logic [15:0] INVALID_ID      = 16'hFFFF;
  localparam logic [31:0] TIMEOUT_RESET   = 32'd1000;
  localparam logic [2:0]  REG_TIMEOUT_IDX = 3'd0;

  localparam logic [3:0] ST_INVALID = 4'd0;
  localparam logic [3:0] ST_PENDING = 4'd1;
  localparam logic [3:0] ST_READY   = 4'd2;
  localparam logic [3:0] ST_TIMEOUT = 4'd3;

  localparam logic [2:0] STS_OK          = 3'd0;
  localparam logic [2:0] STS_NO_FREE     = 3'd1;
  localparam logic [2:0] STS_NOT_FOUND   = 3'd2;
  localparam logic [2:0] STS_CALL_FAILED = 3'd3;
  localparam logic [2:0] STS_NONE_EXP    = 3'd4;

  localparam logic [2:0] K_OBTAIN   = 3'd0;
  localparam logic [2:0] K_RESPONSE = 3'd1;
  localparam logic [2:0] K_CANCEL   = 3'd2;
  localparam logic [2:0] K_OUTCOME  = 3'd3;
  localparam logic [2:0] K_TICK     = 3'd4;
  localparam logic [2:0] K_FREE_ALL = 3'd5;
  localparam logic [2:0] K_RELEASE  = 3'd6;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] request_id;
    logic        is_error;
    logic [3:0]  error_state;
    logic [31:0] now_ms;
    logic        call_failed;
    logic [2:0]  slot_index;
  } ort_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [2:0]  slot;
    logic [15:0] out_request_id;
    logic [3:0]  entry_state;
    logic        last;
  } ort_out_t;

  typedef struct packed {
    logic [3:0]  state;
    logic [15:0] id;
    logic [31:0] stamp;
  } ort_entry_t;

  typedef struct packed {
    logic [SLOT_W-1:0] raddr;
    logic              we;
    logic [SLOT_W-1:0] waddr;
    ort_entry_t        wdata;
    logic              clr_all;
  } ort_mem_req_t;

endpackage

FILE: hw/rtl/ort_slot_mem.sv
// slot table memory with per-entry valid bits; unwritten entries read as free
module ort_slot_mem import ort_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  ort_mem_req_t req,
  output ort_entry_t   rd_entry
);

  ort_entry_t       mem [SLOTS];
  logic [SLOTS-1:0] vbits;
  ort_entry_t       rdata;
  logic             rvalid;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

  always_ff @(posedge clk) begin
    if (rst || req.clr_all) begin
      vbits  <= '0;
      rvalid <= 1'b0;
    end else begin
      if (req.we) begin
        vbits[req.waddr] <= 1'b1;
      end
      rvalid <= vbits[req.raddr];
    end
  end

  always_comb begin
    rd_entry = rdata;
    if (!rvalid) begin
      rd_entry.state = ST_INVALID;
      rd_entry.id    = INVALID_ID;
    end
  end

endmodule

FILE: hw/rtl/outstanding_request_tracker_core.sv
// Outstanding request tracker: a table of SLOTS request slots held in one memory
// with a registered read. A call outcome with call_failed clear, free-all and an
// out-of-range release are answered straight from idle, with busy never raised; the
// undefined kind gives no result. Obtain, response, cancel and failed call outcome
// scan the slots in ascending order, one read-modify-write per cycle, and stop at
// the first match. A release reads its one slot. A tick scans the slots until the
// last or until MAX_RESULTS have expired; each expiry is reported when the next is
// found, the last after the scan. Results appear for one cycle on result_valid and
// cannot be stalled; an item that gives several results ends with result.last set.
module outstanding_request_tracker_core import ort_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  ort_in_t     cmd,
  output logic        result_valid,
  output ort_out_t    result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FLUSH} state_t;

  state_t            st;
  ort_in_t           cmd_q;
  logic [POS_W-1:0]  pos;
  logic [CNT_W-1:0]  nexp;
  logic              buf_full;
  ort_out_t          buf_res;
  logic [15:0]       next_id;
  logic [31:0]       timeout_ms;
  logic              ev_on;
  logic [SLOT_W-1:0] ev_idx;

  ort_mem_req_t req;
  ort_entry_t   ent;

  logic        accept;
  logic        start_scan;
  logic        rel_ok;
  logic        hit;
  logic        last_entry;
  logic        finish;
  logic        issue;
  logic [15:0] alloc_id;
  logic [3:0]  resp_state;
  logic [31:0] age;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_TIMEOUT_IDX[0]) ? timeout_ms : 32'd0;
  assign busy   = (st != S_IDLE);
  assign accept = start && (st == S_IDLE);

  assign rel_ok   = (int'(cmd.slot_index) < SLOTS);
  assign alloc_id = (next_id == INVALID_ID) ? 16'd0 : next_id;
  assign resp_state = cmd_q.is_error ? cmd_q.error_state : ST_READY;
  assign age      = cmd_q.now_ms - ent.stamp;
  assign last_entry = (ev_idx == SLOT_W'(SLOTS - 1));

  always_comb begin
    start_scan = 1'b0;
    case (cmd.kind)
      K_OBTAIN, K_RESPONSE, K_CANCEL, K_TICK: start_scan = 1'b1;
      K_OUTCOME: start_scan = cmd.call_failed;
      K_RELEASE: start_scan = rel_ok;
      default:   start_scan = 1'b0;
    endcase
  end

  always_comb begin
    hit = 1'b0;
    case (cmd_q.kind)
      K_OBTAIN:            hit = (ent.state == ST_INVALID);
      K_RESPONSE:          hit = (ent.id == cmd_q.request_id) && (ent.state == ST_PENDING);
      K_CANCEL, K_OUTCOME: hit = (ent.id == cmd_q.request_id);
      K_TICK:              hit = (ent.state == ST_PENDING) && (age > timeout_ms);
      K_RELEASE:           hit = 1'b1;
      default:             hit = 1'b0;
    endcase
  end

  always_comb begin
    if (cmd_q.kind == K_TICK) begin
      finish = ev_on && ((hit && (nexp == CNT_W'(MAX_RESULTS - 1))) || last_entry);
    end else begin
      finish = ev_on && (hit || last_entry);
    end
  end

  // memory request: next read address and the write-back of the evaluated slot
  always_comb begin
    req       = '0;
    issue     = 1'b0;
    req.raddr = pos[SLOT_W-1:0];
    if (accept && start_scan) begin
      issue     = 1'b1;
      req.raddr = (cmd.kind == K_RELEASE) ? SLOT_W'(cmd.slot_index) : '0;
    end else if (st == S_SCAN) begin
      issue = !finish && (int'(pos) < SLOTS) && (cmd_q.kind != K_RELEASE);
    end
    req.clr_all = accept && (cmd.kind == K_FREE_ALL);
    req.we      = (st == S_SCAN) && ev_on && hit;
    req.waddr   = ev_idx;
    req.wdata   = '{state: ST_INVALID, id: INVALID_ID, stamp: ent.stamp};
    case (cmd_q.kind)
      K_OBTAIN:   req.wdata = '{state: ST_PENDING, id: alloc_id, stamp: cmd_q.now_ms};
      K_RESPONSE: req.wdata.state = resp_state;
      default:    req.wdata.state = ST_INVALID;
    endcase
  end

  ort_slot_mem u_mem (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .rd_entry (ent)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ms <= TIMEOUT_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == REG_TIMEOUT_IDX[0])) begin
      timeout_ms <= pwdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st           <= S_IDLE;
      result_valid <= 1'b0;
      next_id      <= INVALID_ID;
      ev_on        <= 1'b0;
      buf_full     <= 1'b0;
      nexp         <= '0;
      pos          <= '0;
    end else begin
      result_valid <= 1'b0;
      ev_on        <= issue;
      ev_idx       <= req.raddr;
      // the first read of a scan is slot 0 (a release reads only its own slot), so the next one is slot 1
      if (issue) begin
        pos <= (st == S_IDLE) ? POS_W'(1) : pos + POS_W'(1);
      end
      case (st)
        S_IDLE: begin
          if (accept) begin
            cmd_q    <= cmd;
            nexp     <= '0;
            buf_full <= 1'b0;
            if (start_scan) begin
              st <= S_SCAN;
            end else begin
              case (cmd.kind)
                K_OUTCOME: begin
                  result_valid <= 1'b1;
                  result <= '{STS_OK, 3'd0, cmd.request_id, ST_INVALID, 1'b1};
                end
                K_FREE_ALL: begin
                  next_id      <= INVALID_ID;
                  result_valid <= 1'b1;
                  result <= '{STS_OK, 3'd0, INVALID_ID, ST_INVALID, 1'b1};
                end
                K_RELEASE: begin
                  result_valid <= 1'b1;
                  result <= '{STS_NOT_FOUND, cmd.slot_index, INVALID_ID, ST_INVALID, 1'b1};
                end
                default: ;
              endcase
            end
          end
        end
        S_SCAN: begin
          if (ev_on) begin
            if (cmd_q.kind == K_TICK) begin
              if (hit) begin
                nexp     <= nexp + CNT_W'(1);
                buf_full <= 1'b1;
                buf_res  <= '{STS_OK, 3'(ev_idx), ent.id, ST_TIMEOUT, 1'b0};
                if (buf_full) begin
                  result_valid <= 1'b1;
                  result       <= buf_res;
                end
              end
              if (finish) begin
                st <= S_FLUSH;
              end
            end else if (finish) begin
              st           <= S_IDLE;
              result_valid <= 1'b1;
              case (cmd_q.kind)
                K_OBTAIN: begin
                  if (hit) begin
                    next_id <= alloc_id + 16'd1;
                    result  <= '{STS_OK, 3'(ev_idx), alloc_id, ST_PENDING, 1'b1};
                  end else begin
                    result  <= '{STS_NO_FREE, 3'd0, INVALID_ID, ST_INVALID, 1'b1};
                  end
                end
                K_RESPONSE: begin
                  if (hit) begin
                    result <= '{STS_OK, 3'(ev_idx), cmd_q.request_id, resp_state, 1'b1};
                  end else begin
                    result <= '{STS_NOT_FOUND, 3'd0, cmd_q.request_id, ST_INVALID, 1'b1};
                  end
                end
                K_CANCEL: begin
                  result <= '{hit ? STS_OK : STS_NOT_FOUND, hit ? 3'(ev_idx) : 3'd0,
                              cmd_q.request_id, ST_INVALID, 1'b1};
                end
                K_OUTCOME: begin
                  result <= '{STS_CALL_FAILED, hit ? 3'(ev_idx) : 3'd0,
                              cmd_q.request_id, ST_INVALID, 1'b1};
                end
                default: begin
                  result <= '{STS_OK, 3'(ev_idx), ent.id, ST_INVALID, 1'b1};
                end
              endcase
            end
          end
        end
        S_FLUSH: begin
          st           <= S_IDLE;
          result_valid <= 1'b1;
          if (buf_full) begin
            result <= '{buf_res.status, buf_res.slot, buf_res.out_request_id,
                        buf_res.entry_state, 1'b1};
          end else begin
            result <= '{STS_NONE_EXP, 3'd0, INVALID_ID, ST_INVALID, 1'b1};
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: hw/rtl/ort_checker.sv
// port-level checks for the outstanding request tracker, bound to the tracker core
module ort_checker import ort_pkg::*; (
  input logic     clk,
  input logic     rst,
  input logic     start,
  input logic     busy,
  input logic     result_valid,
  input ort_out_t result
);

  // more results follow a non-final one, so the block must still be working
  a_more_follow: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.last |-> busy)
    else $error("non-final result while idle");

  // no result appears out of nowhere after an idle cycle with no transaction
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !busy && !start |=> !result_valid)
    else $error("result without a transaction");

  a_timeout_ok: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.entry_state == ST_TIMEOUT |-> result.status == STS_OK)
    else $error("timeout result with bad status");

  a_no_free_id: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status == STS_NO_FREE |->
      result.out_request_id == INVALID_ID && result.last)
    else $error("failed obtain reports a request id");

endmodule

bind outstanding_request_tracker_core ort_checker u_ort_checker (.*);

FILE: verif/tb_top.sv
// testbench for the outstanding request tracker: queued driver, strobe monitor, tracking model
module tb_top;
  import ort_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  ort_in_t     cmd = '0;
  logic        result_valid;
  ort_out_t    result;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  outstanding_request_tracker_core i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .result_valid(result_valid), .result(result),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // tracker model state
  logic [3:0]  mdl_state [SLOTS];
  logic [15:0] mdl_id    [SLOTS];
  logic [31:0] mdl_stamp [SLOTS];
  logic [15:0] mdl_next_id;
  logic [31:0] mdl_timeout;

  ort_in_t  cmd_queue [$];
  ort_out_t expected_results [$];
  int       error_count = 0;
  int       sent_count = 0;
  bit       driver_hold = 1'b0;
  int       burst_left = 0;
  int       gap_left = 0;

  task automatic report_mismatch(input string what, input ort_out_t got, input ort_out_t want);
    error_count++;
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
  endtask

  function automatic ort_out_t mk(input logic [2:0] st, input logic [2:0] sl,
                                  input logic [15:0] id, input logic [3:0] es);
    ort_out_t r;
    r.status = st; r.slot = sl; r.out_request_id = id; r.entry_state = es; r.last = 1'b1;
    return r;
  endfunction

  function automatic void model_reset();
    for (int i = 0; i < SLOTS; i++) begin
      mdl_state[i] = ST_INVALID; mdl_id[i] = INVALID_ID; mdl_stamp[i] = '0;
    end
    mdl_next_id = INVALID_ID;
  endfunction

  function automatic void predict_transaction(input ort_in_t c);
    int hit;
    int n;
    ort_out_t r;
    hit = -1;
    n = 0;
    case (c.kind)
      K_OBTAIN: begin
        for (int i = 0; i < SLOTS; i++) if (hit < 0 && mdl_state[i] == ST_INVALID) hit = i;
        if (hit < 0) expected_results.push_back(mk(STS_NO_FREE, 3'd0, INVALID_ID, ST_INVALID));
        else begin
          if (mdl_next_id == INVALID_ID) mdl_next_id = 16'd0;
          mdl_stamp[hit] = c.now_ms; mdl_id[hit] = mdl_next_id; mdl_state[hit] = ST_PENDING;
          mdl_next_id = mdl_next_id + 16'd1;
          expected_results.push_back(mk(STS_OK, hit[2:0], mdl_id[hit], ST_PENDING));
        end
      end
      K_RESPONSE: begin
        for (int i = 0; i < SLOTS; i++)
          if (hit < 0 && mdl_id[i] == c.request_id && mdl_state[i] == ST_PENDING) hit = i;
        if (hit < 0)
          expected_results.push_back(mk(STS_NOT_FOUND, 3'd0, c.request_id, ST_INVALID));
        else begin
          mdl_id[hit] = INVALID_ID;
          mdl_state[hit] = c.is_error ? c.error_state : ST_READY;
          expected_results.push_back(mk(STS_OK, hit[2:0], c.request_id, mdl_state[hit]));
        end
      end
      K_CANCEL, K_OUTCOME: begin
        if (c.kind == K_OUTCOME && !c.call_failed)
          expected_results.push_back(mk(STS_OK, 3'd0, c.request_id, ST_INVALID));
        else begin
          for (int i = 0; i < SLOTS; i++) if (hit < 0 && mdl_id[i] == c.request_id) hit = i;
          if (hit >= 0) begin
            mdl_state[hit] = ST_INVALID; mdl_id[hit] = INVALID_ID;
          end
          expected_results.push_back(mk(c.kind == K_OUTCOME ? STS_CALL_FAILED :
                                        (hit >= 0 ? STS_OK : STS_NOT_FOUND),
                                        hit >= 0 ? hit[2:0] : 3'd0, c.request_id, ST_INVALID));
        end
      end
      K_TICK: begin
        for (int i = 0; i < SLOTS; i++)
          if (n < MAX_RESULTS && mdl_state[i] == ST_PENDING &&
              (c.now_ms - mdl_stamp[i]) > mdl_timeout) begin
            r = mk(STS_OK, i[2:0], mdl_id[i], ST_TIMEOUT);
            r.last = 1'b0;
            expected_results.push_back(r);
            mdl_state[i] = ST_INVALID; mdl_id[i] = INVALID_ID;
            n++;
          end
        if (n == 0) expected_results.push_back(mk(STS_NONE_EXP, 3'd0, INVALID_ID, ST_INVALID));
        else expected_results[$].last = 1'b1;
      end
      K_FREE_ALL: begin
        for (int i = 0; i < SLOTS; i++) begin
          mdl_state[i] = ST_INVALID; mdl_id[i] = INVALID_ID;
        end
        mdl_next_id = INVALID_ID;
        expected_results.push_back(mk(STS_OK, 3'd0, INVALID_ID, ST_INVALID));
      end
      K_RELEASE: begin
        expected_results.push_back(mk(STS_OK, c.slot_index, mdl_id[c.slot_index], ST_INVALID));
        mdl_state[c.slot_index] = ST_INVALID; mdl_id[c.slot_index] = INVALID_ID;
      end
      default: ;
    endcase
  endfunction

  // driver: bursts and gaps, presents at falling edge
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (start && busy) begin
      // keep holding the same transaction
    end else begin
      if (start) sent_count <= sent_count + 1;
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else if (!driver_hold && cmd_queue.size() > 0) begin
        cmd <= cmd_queue.pop_front();
        start <= 1'b1;
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 12);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: acceptance and result checking at rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) predict_transaction(cmd);
      if (result_valid) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", result, '0);
        end else begin
          ort_out_t want;
          want = expected_results.pop_front();
          if (result.status !== want.status) report_mismatch("status", result, want);
          if (result.slot !== want.slot) report_mismatch("slot", result, want);
          if (result.out_request_id !== want.out_request_id)
            report_mismatch("request id", result, want);
          if (result.entry_state !== want.entry_state) report_mismatch("entry state", result, want);
          if (result.last !== want.last) report_mismatch("last", result, want);
        end
      end
    end
  end

  function automatic ort_in_t rand_cmd(input logic [2:0] k);
    ort_in_t c;
    c.kind = k;
    c.request_id = $urandom_range(0, 3) == 0 ? 16'($urandom) :
                   ($urandom_range(0, 5) == 0 ? INVALID_ID : 16'($urandom_range(0, 20)));
    c.is_error = 1'($urandom_range(0, 1));
    c.error_state = 4'($urandom_range(0, 15));
    c.now_ms = $urandom;
    c.call_failed = 1'($urandom_range(0, 1));
    c.slot_index = 3'($urandom_range(0, 7));
    return c;
  endfunction

  function automatic ort_in_t op(input logic [2:0] k, input logic [15:0] id,
                                 input logic [31:0] now);
    ort_in_t c;
    c = rand_cmd(k);
    c.request_id = id;
    c.now_ms = now;
    return c;
  endfunction

  task automatic wait_drain();
    while (cmd_queue.size() > 0 || start || expected_results.size() > 0) @(posedge clk);
    repeat (SLOTS + 4) @(posedge clk);
  endtask

  task automatic apb_write(input logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {REG_TIMEOUT_IDX[0], 2'b00}; pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    mdl_timeout = value;
  endtask

  task automatic random_phase(input int count, input logic [31:0] base, input int span);
    logic [31:0] t;
    ort_in_t c;
    int sel;
    t = base;
    for (int i = 0; i < count; i++) begin
      t = t + $urandom_range(0, span);
      sel = $urandom_range(0, 99);
      if (sel < 30) c = op(K_OBTAIN, 16'd0, t);
      else if (sel < 55) c = op(K_RESPONSE, ($urandom_range(0, 3) == 0) ?
                                16'($urandom) : 16'($urandom_range(0, 24)), t);
      else if (sel < 63) c = rand_cmd(K_CANCEL);
      else if (sel < 71) c = rand_cmd(K_OUTCOME);
      else if (sel < 88) c = op(K_TICK, 16'd0, t);
      else if (sel < 91) c = rand_cmd(K_FREE_ALL);
      else if (sel < 98) c = rand_cmd(K_RELEASE);
      else c = rand_cmd(3'd7);
      if (c.kind == K_TICK && $urandom_range(0, 3) == 0) c.now_ms = $urandom;
      cmd_queue.push_back(c);
    end
  endtask

  initial begin
    model_reset();
    mdl_timeout = TIMEOUT_RESET;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: fill table, overflow, responses, cancels, ticks, extremes
    for (int i = 0; i < SLOTS; i++) cmd_queue.push_back(op(K_OBTAIN, 16'd0, 32'd100 * i));
    cmd_queue.push_back(op(K_OBTAIN, 16'd0, 32'd0));
    begin
      ort_in_t c;
      c = op(K_RESPONSE, 16'd0, 32'd0); c.is_error = 1'b0; cmd_queue.push_back(c);
      c = op(K_RESPONSE, 16'd1, 32'd0); c.is_error = 1'b1; c.error_state = 4'd0;
      cmd_queue.push_back(c);
      c = op(K_RESPONSE, 16'd2, 32'd0); c.is_error = 1'b1; c.error_state = 4'd1;
      cmd_queue.push_back(c);
      c = op(K_RESPONSE, 16'd3, 32'd0); c.is_error = 1'b1; c.error_state = 4'd15;
      cmd_queue.push_back(c);
      cmd_queue.push_back(op(K_RESPONSE, INVALID_ID, 32'd0));
      cmd_queue.push_back(op(K_CANCEL, INVALID_ID, 32'd0));
      cmd_queue.push_back(op(K_CANCEL, 16'd999, 32'd0));
      c = op(K_OUTCOME, 16'd4, 32'd0); c.call_failed = 1'b1; cmd_queue.push_back(c);
      c = op(K_OUTCOME, 16'd5, 32'd0); c.call_failed = 1'b0; cmd_queue.push_back(c);
      c = op(K_OUTCOME, 16'd777, 32'd0); c.call_failed = 1'b1; cmd_queue.push_back(c);
      cmd_queue.push_back(op(K_TICK, 16'd0, 32'd500));
      cmd_queue.push_back(op(K_TICK, 16'd0, 32'hFFFF_FFFF));
      c = rand_cmd(K_RELEASE); c.slot_index = 3'd7; cmd_queue.push_back(c);
      c = rand_cmd(K_RELEASE); c.slot_index = 3'd0; cmd_queue.push_back(c);
      cmd_queue.push_back(rand_cmd(3'd7));
      cmd_queue.push_back(rand_cmd(K_FREE_ALL));
    end
    // pause until every expected result has come
    wait_drain();

    // full tick: eight slots expiring together, with wrapped time
    apb_write(32'd0);
    for (int i = 0; i < SLOTS; i++) cmd_queue.push_back(op(K_OBTAIN, 16'd0, 32'hFFFF_FFF0 + i));
    cmd_queue.push_back(op(K_TICK, 16'd0, 32'd20));
    random_phase(100, 0, 3);
    wait_drain();

    apb_write(32'hFFFF_FFFF);
    random_phase(60, 32'h8000_0000, 1 << 20);
    wait_drain();

    apb_write(32'd50);
    random_phase(120, 0, 20);
    wait_drain();

    apb_write(TIMEOUT_RESET);
    random_phase(80, 32'hFFFF_F000, 200);
    wait_drain();

    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end
endmodule

FILE: outstanding_request_tracker_core.f
hw/rtl/ort_pkg.sv
hw/rtl/ort_slot_mem.sv
hw/rtl/outstanding_request_tracker_core.sv
hw/rtl/ort_checker.sv
verif/tb_top.sv
